/* hw/rtl/assert_macros.svh */
// assertion helpers shared by the checker files
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, disabled while reset is high
`define CKE_ASSERT_IMP(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication, disabled while reset is high
`define CKE_ASSERT_NXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

/* hw/rtl/cke_pkg.sv */
// ----------------------------------------------------------------------------
// cke_pkg
// Types, constants and helpers of the ChaCha keystream XOR block.
// ----------------------------------------------------------------------------
package cke_pkg;

   localparam int BLOCK_BYTES = 64;
   localparam int WORDS       = 16;
   localparam int LANES       = 4;
   localparam int KEY_PAIRS   = 4;
   localparam int OFFSET_W    = $clog2(BLOCK_BYTES);
   localparam int POS_W       = OFFSET_W + 1;
   localparam int WIDX_W      = $clog2(WORDS);

   localparam int QUEUE_DEPTH = 4;
   localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
   localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

   localparam int CSR_ADDR_W  = 6;
   localparam int CSR_DATA_W  = 64;
   localparam int ROUNDS_W    = 5;
   localparam logic [ROUNDS_W-1:0] ROUNDS_RESET = 5'd20;

   typedef logic [31:0] word_type;

   localparam word_type SIGMA [4] = '{32'h61707865, 32'h3320646E,
                                      32'h79622D32, 32'h6B206574};

   typedef enum logic [2:0] {
      REG_KEY0   = 3'd0,
      REG_KEY1   = 3'd1,
      REG_KEY2   = 3'd2,
      REG_KEY3   = 3'd3,
      REG_NONCE  = 3'd4,
      REG_ROUNDS = 3'd5
   } csr_reg_type;

   typedef struct packed {
      logic [KEY_PAIRS-1:0][63:0] key;
      logic [63:0]                nonce;
      logic [ROUNDS_W-1:0]        rounds;
   } cfg_type;

   // one queued request: data byte, where it lands in the block, and
   // whether a fresh block has to be made first
   typedef struct packed {
      logic [7:0]          data;
      logic [OFFSET_W-1:0] offset;
      logic                new_block;
   } qitem_type;

   typedef enum logic [1:0] {
      BK_WAIT,
      BK_ROUND,
      BK_FINAL
   } back_state_type;

   function automatic word_type rol32(input word_type v, input int unsigned s);
      return (v << s) | (v >> (32 - s));
   endfunction

endpackage

/* hw/rtl/cke_if.sv */
// ----------------------------------------------------------------------------
// cke_req_if / cke_rsp_if
// Valid/ready channels for the request bytes and the result bytes.
// ----------------------------------------------------------------------------
interface cke_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] data_byte;

   modport source (output valid, output data_byte, input ready);
   modport sink   (input valid, input data_byte, output ready);
endinterface

interface cke_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] cipher_byte;

   modport source (output valid, output cipher_byte, input ready);
   modport sink   (input valid, input cipher_byte, output ready);
endinterface

/* hw/rtl/cke_csr.sv */
// ----------------------------------------------------------------------------
// cke_csr
// Configuration registers behind an APB-style port; flags nonce writes.
// ----------------------------------------------------------------------------
module cke_csr (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            csr_psel,
   input  logic                            csr_penable,
   input  logic                            csr_pwrite,
   input  logic [cke_pkg::CSR_ADDR_W-1:0]  csr_paddr,
   input  logic [cke_pkg::CSR_DATA_W-1:0]  csr_pwdata,
   output logic [cke_pkg::CSR_DATA_W-1:0]  csr_prdata,
   output logic                            csr_pready,
   output cke_pkg::cfg_type                cfg,
   output logic                            restart
);
   import cke_pkg::*;

   logic [63:0]         key_ff [KEY_PAIRS];
   logic [63:0]         key_in [KEY_PAIRS];
   logic [63:0]         nonce_ff, nonce_in;
   logic [ROUNDS_W-1:0] rounds_ff, rounds_in;
   logic                wr;
   csr_reg_type         idx;

   assign csr_pready = 1'b1;
   assign wr  = csr_psel & csr_penable & csr_pwrite;
   assign idx = csr_reg_type'(csr_paddr[CSR_ADDR_W-1:3]);

   always_comb begin
      key_in    = key_ff;
      nonce_in  = nonce_ff;
      rounds_in = rounds_ff;
      restart   = 1'b0;
      if (wr) begin
         unique case (idx)
            REG_KEY0:   key_in[0] = csr_pwdata;
            REG_KEY1:   key_in[1] = csr_pwdata;
            REG_KEY2:   key_in[2] = csr_pwdata;
            REG_KEY3:   key_in[3] = csr_pwdata;
            REG_NONCE: begin
               nonce_in = csr_pwdata;
               restart  = 1'b1;
            end
            REG_ROUNDS: rounds_in = csr_pwdata[ROUNDS_W-1:0];
            default:    ;
         endcase
      end
   end

   always_comb begin
      unique case (idx)
         REG_KEY0:   csr_prdata = key_ff[0];
         REG_KEY1:   csr_prdata = key_ff[1];
         REG_KEY2:   csr_prdata = key_ff[2];
         REG_KEY3:   csr_prdata = key_ff[3];
         REG_NONCE:  csr_prdata = nonce_ff;
         REG_ROUNDS: csr_prdata = CSR_DATA_W'(rounds_ff);
         default:    csr_prdata = '0;
      endcase
   end

   always_comb begin
      for (int k = 0; k < KEY_PAIRS; k++) begin
         cfg.key[k] = key_ff[k];
      end
      cfg.nonce  = nonce_ff;
      cfg.rounds = rounds_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k < KEY_PAIRS; k++) begin
            key_ff[k] <= '0;
         end
         nonce_ff  <= '0;
         rounds_ff <= ROUNDS_RESET;
      end else begin
         key_ff    <= key_in;
         nonce_ff  <= nonce_in;
         rounds_ff <= rounds_in;
      end
   end

endmodule

/* hw/rtl/cke_front.sv */
// ----------------------------------------------------------------------------
// cke_front
// Takes request bytes, tracks the block position and tags each byte with
// its offset and whether it opens a new keystream block.
// ----------------------------------------------------------------------------
module cke_front (
   input  logic               clock,
   input  logic               reset,
   cke_req_if.sink            req,
   input  logic               restart,
   output logic               push_valid,
   input  logic               push_ready,
   output cke_pkg::qitem_type push_item
);
   import cke_pkg::*;

   logic [POS_W-1:0]    pos_ff, pos_in;
   logic                need_block;
   logic [OFFSET_W-1:0] offset;

   // position zero means no block yet
   assign need_block = (pos_ff == '0) || (pos_ff >= POS_W'(BLOCK_BYTES));
   assign offset     = need_block ? '0 : pos_ff[OFFSET_W-1:0];

   assign req.ready  = push_ready;
   assign push_valid = req.valid;

   always_comb begin
      push_item.data      = req.data_byte;
      push_item.offset    = offset;
      push_item.new_block = need_block;
   end

   always_comb begin
      priority if (restart) begin
         pos_in = '0;
      end else if (req.valid && push_ready) begin
         pos_in = POS_W'({1'b0, offset}) + POS_W'(1);
      end else begin
         pos_in = pos_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff <= '0;
      end else begin
         pos_ff <= pos_in;
      end
   end

endmodule

/* hw/rtl/cke_queue.sv */
// ----------------------------------------------------------------------------
// cke_queue
// Short FIFO of tagged requests between the front and back ends.
// ----------------------------------------------------------------------------
module cke_queue (
   input  logic               clock,
   input  logic               reset,
   input  logic               push_valid,
   output logic               push_ready,
   input  cke_pkg::qitem_type push_item,
   output logic               pop_valid,
   input  logic               pop_ready,
   output cke_pkg::qitem_type pop_item
);
   import cke_pkg::*;

   qitem_type          entries_ff [QUEUE_DEPTH];
   qitem_type          entry_in;
   logic [QPTR_W-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [QCNT_W-1:0]  count_ff, count_in;
   logic               do_push, do_pop;

   assign push_ready = (count_ff != QCNT_W'(QUEUE_DEPTH));
   assign pop_valid  = (count_ff != '0);
   assign pop_item   = entries_ff[rd_ptr_ff];
   assign do_push    = push_valid & push_ready;
   assign do_pop     = pop_valid & pop_ready;
   assign entry_in   = push_item;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + QPTR_W'(1);
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + QPTR_W'(1);
      end
      unique case ({do_push, do_pop})
         2'b10:   count_in = count_ff + QCNT_W'(1);
         2'b01:   count_in = count_ff - QCNT_W'(1);
         default: count_in = count_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entries_ff[wr_ptr_ff] <= entry_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule

/* hw/rtl/cke_back.sv */
// ----------------------------------------------------------------------------
// cke_back
// Generates keystream blocks with four quarter-round lanes, one add-xor-rotate
// step of the quarter-round per cycle, and XORs queued bytes into the result.
// ----------------------------------------------------------------------------
module cke_back (
   input  logic               clock,
   input  logic               reset,
   input  cke_pkg::cfg_type   cfg,
   input  logic               restart,
   input  logic               q_valid,
   input  cke_pkg::qitem_type q_item,
   output logic               q_pop,
   cke_rsp_if.source          rsp
);
   import cke_pkg::*;

   back_state_type state_ff, state_in;
   word_type       w_ff [WORDS];
   word_type       w_in [WORDS];
   word_type       w_step [WORDS];
   word_type       ks_ff [WORDS];
   word_type       ks_in [WORDS];
   word_type       init [WORDS];
   logic [63:0]    counter_ff, counter_in;
   logic [2:0]     step_ff, step_in;
   logic [3:0]     dr_ff, dr_in;
   logic           fresh_ff, fresh_in;
   logic           rsp_valid_ff, rsp_valid_in;
   logic [7:0]     byte_ff, byte_in;
   logic [3:0]     n_dr;
   logic           last_step;
   logic           out_free;
   logic           start_gen;
   word_type       ks_word;
   logic [7:0]     ks_byte;

   assign n_dr      = cfg.rounds[ROUNDS_W-1:1];
   assign last_step = (step_ff == 3'd7) && (dr_ff == n_dr - 4'd1);
   assign out_free  = !rsp_valid_ff || rsp.ready;
   assign start_gen = (state_ff == BK_WAIT) && q_valid && q_item.new_block && !fresh_ff;
   // a byte can leave once its block is in place and the output slot frees
   assign q_pop     = (state_ff == BK_WAIT) && q_valid && out_free &&
                      (!q_item.new_block || fresh_ff);

   assign ks_word = ks_ff[q_item.offset[OFFSET_W-1:2]];
   assign ks_byte = ks_word[{q_item.offset[1:0], 3'b000} +: 8];

   assign rsp.valid       = rsp_valid_ff;
   assign rsp.cipher_byte = byte_ff;

   always_comb begin
      for (int i = 0; i < 4; i++) begin
         init[i]         = SIGMA[i];
         init[4 + 2 * i] = cfg.key[i][31:0];
         init[5 + 2 * i] = cfg.key[i][63:32];
      end
      init[12] = counter_ff[31:0];
      init[13] = counter_ff[63:32];
      init[14] = cfg.nonce[31:0];
      init[15] = cfg.nonce[63:32];
   end

   // step_ff[2] picks diagonal rounds, step_ff[1:0] the add-xor-rotate step
   always_comb begin
      logic [WIDX_W-1:0] ia, ib, ic, id;
      logic [WIDX_W-1:0] ip, iq, ir;
      word_type          sum, mix;
      w_step = w_ff;
      for (int i = 0; i < LANES; i++) begin
         ia = WIDX_W'(i);
         ib = step_ff[2] ? WIDX_W'(4 + ((i + 1) & 3))  : WIDX_W'(4 + i);
         ic = step_ff[2] ? WIDX_W'(8 + ((i + 2) & 3))  : WIDX_W'(8 + i);
         id = step_ff[2] ? WIDX_W'(12 + ((i + 3) & 3)) : WIDX_W'(12 + i);
         unique case (step_ff[1:0])
            2'd0, 2'd2: begin
               ip = ia;
               iq = ib;
               ir = id;
            end
            default: begin
               ip = ic;
               iq = id;
               ir = ib;
            end
         endcase
         sum = w_ff[ip] + w_ff[iq];
         mix = w_ff[ir] ^ sum;
         w_step[ip] = sum;
         unique case (step_ff[1:0])
            2'd0:    w_step[ir] = rol32(mix, 16);
            2'd1:    w_step[ir] = rol32(mix, 12);
            2'd2:    w_step[ir] = rol32(mix, 8);
            default: w_step[ir] = rol32(mix, 7);
         endcase
      end
   end

   always_comb begin
      unique case (state_ff)
         BK_WAIT: begin
            if (start_gen) begin
               state_in = (n_dr == '0) ? BK_FINAL : BK_ROUND;
            end else begin
               state_in = BK_WAIT;
            end
         end
         BK_ROUND: state_in = last_step ? BK_FINAL : BK_ROUND;
         BK_FINAL: state_in = BK_WAIT;
         default:  state_in = BK_WAIT;
      endcase
   end

   always_comb begin
      w_in         = w_ff;
      ks_in        = ks_ff;
      step_in      = step_ff;
      dr_in        = dr_ff;
      counter_in   = counter_ff;
      fresh_in     = fresh_ff;
      rsp_valid_in = rsp_valid_ff;
      byte_in      = byte_ff;
      if (rsp.ready) begin
         rsp_valid_in = 1'b0;
      end
      if (q_pop) begin
         rsp_valid_in = 1'b1;
         byte_in      = q_item.data ^ ks_byte;
         fresh_in     = 1'b0;
      end
      unique case (state_ff)
         BK_WAIT: begin
            if (start_gen) begin
               w_in    = init;
               step_in = '0;
               dr_in   = '0;
            end
         end
         BK_ROUND: begin
            w_in    = w_step;
            step_in = step_ff + 3'd1;
            if (step_ff == 3'd7) begin
               dr_in = dr_ff + 4'd1;
            end
         end
         BK_FINAL: begin
            for (int i = 0; i < WORDS; i++) begin
               ks_in[i] = w_ff[i] + init[i];
            end
            counter_in = counter_ff + 64'd1;
            fresh_in   = 1'b1;
         end
         default: ;
      endcase
      if (restart) begin
         counter_in = '0;
      end
   end

   always_ff @(posedge clock) begin
      w_ff    <= w_in;
      ks_ff   <= ks_in;
      byte_ff <= byte_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= BK_WAIT;
         step_ff      <= '0;
         dr_ff        <= '0;
         counter_ff   <= '0;
         fresh_ff     <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         step_ff      <= step_in;
         dr_ff        <= dr_in;
         counter_ff   <= counter_in;
         fresh_ff     <= fresh_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule

/* hw/rtl/chacha_keystream_xor.sv */
// ----------------------------------------------------------------------------
// chacha_keystream_xor
// ChaCha stream cipher (64-bit nonce, 64-bit counter): each request byte is
// XORed with the next keystream byte.
// ----------------------------------------------------------------------------
//   channel  direction  payload           width
//   req      in         data_byte         8
//   rsp      out        cipher_byte       8
//   csr      in/out     64-bit registers  apb, 8-byte stride
//
// A byte within the current block passes through the queue and the result
// register on its way to rsp. A byte that opens a block waits for the shared
// four-lane quarter-round unit, which runs floor(rounds/2) double rounds.
// Synchronous active-high reset; no clearing pass.
// A four-entry queue keeps req open until full while rounds run or rsp stalls.
module chacha_keystream_xor (
   input  logic                            clock,
   input  logic                            reset,
   cke_req_if.sink                         req,
   cke_rsp_if.source                       rsp,
   input  logic                            csr_psel,
   input  logic                            csr_penable,
   input  logic                            csr_pwrite,
   input  logic [cke_pkg::CSR_ADDR_W-1:0]  csr_paddr,
   input  logic [cke_pkg::CSR_DATA_W-1:0]  csr_pwdata,
   output logic [cke_pkg::CSR_DATA_W-1:0]  csr_prdata,
   output logic                            csr_pready
);
   import cke_pkg::*;

   cfg_type   cfg;
   logic      restart;
   logic      push_valid, push_ready;
   qitem_type push_item;
   logic      pop_valid, pop_ready;
   qitem_type pop_item;

   cke_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .cfg         (cfg),
      .restart     (restart)
   );

   cke_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req        (req),
      .restart    (restart),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_item  (push_item)
   );

   cke_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_item  (push_item),
      .pop_valid  (pop_valid),
      .pop_ready  (pop_ready),
      .pop_item   (pop_item)
   );

   cke_back u_back (
      .clock   (clock),
      .reset   (reset),
      .cfg     (cfg),
      .restart (restart),
      .q_valid (pop_valid),
      .q_item  (pop_item),
      .q_pop   (pop_ready),
      .rsp     (rsp)
   );

endmodule

/* hw/rtl/cke_checker.sv */
// ----------------------------------------------------------------------------
// cke_checker
// Port-level checks of the keystream block, bound to the top level.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module cke_checker (
   input logic                            clock,
   input logic                            reset,
   input logic                            rsp_valid,
   input logic                            rsp_ready,
   input logic [7:0]                      rsp_cipher_byte,
   input logic                            csr_psel,
   input logic                            csr_penable,
   input logic                            csr_pwrite,
   input logic [cke_pkg::CSR_ADDR_W-1:0]  csr_paddr,
   input logic [cke_pkg::CSR_DATA_W-1:0]  csr_pwdata,
   input logic [cke_pkg::CSR_DATA_W-1:0]  csr_prdata,
   input logic                            csr_pready
);
   import cke_pkg::*;

   logic wr, rd;
   logic [CSR_ADDR_W-1:0] key0_addr, rounds_addr;

   assign wr          = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign rd          = csr_psel && !csr_pwrite;
   assign key0_addr   = CSR_ADDR_W'(8 * REG_KEY0);
   assign rounds_addr = CSR_ADDR_W'(8 * REG_ROUNDS);

   `CKE_ASSERT_NXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_cipher_byte), "stalled result changed")
   `CKE_ASSERT_IMP(a_rsp_after_reset, clock, reset, $past(reset), !rsp_valid, "result right after reset")
   `CKE_ASSERT_IMP(a_pready, clock, reset, 1'b1, csr_pready, "pready dropped")
   `CKE_ASSERT_IMP(a_key_readback, clock, reset, wr && csr_paddr == key0_addr ##1 rd && csr_paddr == key0_addr, csr_prdata == $past(csr_pwdata), "key readback mismatch")
   `CKE_ASSERT_IMP(a_rounds_readback, clock, reset, wr && csr_paddr == rounds_addr ##1 rd && csr_paddr == rounds_addr, csr_prdata == CSR_DATA_W'($past(csr_pwdata[ROUNDS_W-1:0])), "rounds readback mismatch")

endmodule

bind chacha_keystream_xor cke_checker u_cke_checker (
   .clock           (clock),
   .reset           (reset),
   .rsp_valid       (rsp.valid),
   .rsp_ready       (rsp.ready),
   .rsp_cipher_byte (rsp.cipher_byte),
   .csr_psel        (csr_psel),
   .csr_penable     (csr_penable),
   .csr_pwrite      (csr_pwrite),
   .csr_paddr       (csr_paddr),
   .csr_pwdata      (csr_pwdata),
   .csr_prdata      (csr_prdata),
   .csr_pready      (csr_pready)
);

/* tb/sv/chacha_keystream_xor_test.sv */
// ----------------------------------------------------------------------------
// chacha_keystream_xor_test
// Drives byte requests through the cipher and checks every result byte against
// an in-bench ChaCha keystream predictor, across several key, nonce and round
// settings, with random gaps on both channels.
// ----------------------------------------------------------------------------
module chacha_keystream_xor_test;
   timeunit 1ns;
   timeprecision 1ps;

   import cke_pkg::*;

   localparam int CYCLE_LIMIT  = 1_500_000;
   localparam int RANDOM_BYTES = 2000;
   localparam int DRAIN_CYCLES = 150;

   class cipher_scoreboard;
      logic [63:0]         key_pair [KEY_PAIRS];
      logic [63:0]         nonce_word;
      logic [63:0]         block_count;
      logic [ROUNDS_W-1:0] round_total;
      word_type            keystream [WORDS];
      word_type            mix [WORDS];
      int unsigned         used_bytes;
      logic [7:0]          expected_cipher [$];
      int unsigned         failures;

      function new();
         foreach (key_pair[k]) key_pair[k] = '0;
         nonce_word  = '0;
         block_count = '0;
         round_total = ROUNDS_RESET;
         used_bytes  = 0;
         failures    = 0;
      endfunction

      function void write_reg(csr_reg_type r, logic [63:0] v);
         case (r)
            REG_KEY0, REG_KEY1, REG_KEY2, REG_KEY3: begin
               key_pair[int'(r)] = v;
            end
            REG_NONCE: begin
               nonce_word  = v;
               block_count = '0;
               used_bytes  = 0;
            end
            REG_ROUNDS: begin
               round_total = v[ROUNDS_W-1:0];
            end
            default: ;
         endcase
      endfunction

      function void quarter_round(int a, int b, int c, int d);
         mix[a] = mix[a] + mix[b]; mix[d] = mix[d] ^ mix[a];
         mix[d] = {mix[d][15:0], mix[d][31:16]};
         mix[c] = mix[c] + mix[d]; mix[b] = mix[b] ^ mix[c];
         mix[b] = {mix[b][19:0], mix[b][31:20]};
         mix[a] = mix[a] + mix[b]; mix[d] = mix[d] ^ mix[a];
         mix[d] = {mix[d][23:0], mix[d][31:24]};
         mix[c] = mix[c] + mix[d]; mix[b] = mix[b] ^ mix[c];
         mix[b] = {mix[b][24:0], mix[b][31:25]};
      endfunction

      function void refill_keystream();
         word_type seed [WORDS];
         for (int i = 0; i < 4; i++) seed[i] = SIGMA[i];
         for (int k = 0; k < KEY_PAIRS; k++) begin
            seed[4 + 2*k] = key_pair[k][31:0];
            seed[5 + 2*k] = key_pair[k][63:32];
         end
         seed[12] = block_count[31:0];
         seed[13] = block_count[63:32];
         seed[14] = nonce_word[31:0];
         seed[15] = nonce_word[63:32];
         mix = seed;
         // odd round counts drop the trailing single round
         repeat (int'(round_total >> 1)) begin
            quarter_round(0, 4, 8, 12);
            quarter_round(1, 5, 9, 13);
            quarter_round(2, 6, 10, 14);
            quarter_round(3, 7, 11, 15);
            quarter_round(0, 5, 10, 15);
            quarter_round(1, 6, 11, 12);
            quarter_round(2, 7, 8, 13);
            quarter_round(3, 4, 9, 14);
         end
         for (int i = 0; i < WORDS; i++) keystream[i] = mix[i] + seed[i];
         block_count = block_count + 64'd1;
      endfunction

      function void note_plain(logic [7:0] plain);
         logic [7:0] ks;
         if (used_bytes == 0 || used_bytes >= BLOCK_BYTES) begin
            refill_keystream();
            used_bytes = 0;
         end
         ks = 8'(keystream[used_bytes / 4] >> (8 * (used_bytes % 4)));
         expected_cipher.push_back(plain ^ ks);
         used_bytes++;
      endfunction

      function void check_cipher(logic [7:0] got);
         logic [7:0] want;
         if (expected_cipher.size() == 0) begin
            $error("cipher_byte: expected none, got %02h", got);
            failures++;
            return;
         end
         want = expected_cipher.pop_front();
         if (got !== want) begin
            $error("cipher_byte: expected %02h, got %02h", want, got);
            failures++;
         end
      endfunction

      function int pending();
         return expected_cipher.size();
      endfunction
   endclass

   logic clock = 1'b0;
   logic reset = 1'b1;

   logic                  csr_psel;
   logic                  csr_penable;
   logic                  csr_pwrite;
   logic [CSR_ADDR_W-1:0] csr_paddr;
   logic [CSR_DATA_W-1:0] csr_pwdata;
   logic [CSR_DATA_W-1:0] csr_prdata;
   logic                  csr_pready;

   cke_req_if req_if ();
   cke_rsp_if rsp_if ();

   cipher_scoreboard sb;
   bit send_gaps;
   bit recv_stalls;
   int cycle_count = 0;

   chacha_keystream_xor dut (
      .clock       (clock),
      .reset       (reset),
      .req         (req_if),
      .rsp         (rsp_if),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   always #5 clock = ~clock;

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("** chacha_keystream_xor: FAILED **");
         $finish;
      end
   end

   // mostly no gap, some short ones, a few long
   function automatic int idle_span(bit enabled);
      int unsigned r;
      r = $urandom_range(0, 99);
      if (!enabled || r < 60) return 0;
      if (r < 90) return $urandom_range(1, 3);
      if (r < 98) return $urandom_range(4, 12);
      return $urandom_range(20, 60);
   endfunction

   function automatic logic [63:0] pick_word();
      int unsigned r;
      r = $urandom_range(0, 7);
      if (r == 0) return '0;
      if (r == 1) return '1;
      return {$urandom, $urandom};
   endfunction

   function automatic logic [63:0] pick_rounds();
      case ($urandom_range(0, 7))
         0: return 64'd0;
         1: return 64'd1;
         2: return 64'd8;
         3: return 64'd12;
         4: return 64'd30;
         5: return 64'd31;
         6: return 64'd20;
         default: return 64'($urandom_range(0, 31));
      endcase
   endfunction

   function automatic logic [7:0] pick_byte();
      case ($urandom_range(0, 9))
         0: return 8'h00;
         1: return 8'hFF;
         default: return 8'($urandom_range(0, 255));
      endcase
   endfunction

   task automatic csr_write(csr_reg_type r, logic [63:0] v);
      @(negedge clock);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= CSR_ADDR_W'({r, 3'b000});
      csr_pwdata  <= v;
      @(negedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (csr_pready !== 1'b1);
      sb.write_reg(r, v);
      @(negedge clock);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
   endtask

   // returns at the falling edge after the request was taken
   task automatic send_byte(logic [7:0] b);
      int gap;
      gap = idle_span(send_gaps);
      if (gap > 0) begin
         req_if.valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_if.valid     <= 1'b1;
      req_if.data_byte <= b;
      do @(posedge clock); while (req_if.ready !== 1'b1);
      sb.note_plain(b);
      @(negedge clock);
   endtask

   task automatic end_burst();
      req_if.valid <= 1'b0;
   endtask

   task automatic wait_idle();
      while (sb.pending() != 0) @(posedge clock);
      repeat (4) @(negedge clock);
   endtask

   task automatic random_setup();
      for (int k = 0; k < KEY_PAIRS; k++) begin
         if ($urandom_range(0, 2) == 0) csr_write(csr_reg_type'(k), pick_word());
      end
      if ($urandom_range(0, 1) == 0) csr_write(REG_ROUNDS, pick_rounds());
      if ($urandom_range(0, 1) == 0) csr_write(REG_NONCE, pick_word());
   endtask

   // result side: random stalls, checks at the rising edge
   initial begin
      int stall_left;
      stall_left     = 0;
      rsp_if.ready   = 1'b0;
      while (reset !== 1'b0) @(negedge clock);
      forever begin
         if (stall_left == 0) stall_left = idle_span(recv_stalls);
         rsp_if.ready <= (stall_left == 0);
         if (stall_left > 0) stall_left--;
         @(posedge clock);
         if (rsp_if.valid === 1'b1 && rsp_if.ready === 1'b1)
            sb.check_cipher(rsp_if.cipher_byte);
         @(negedge clock);
      end
   end

   initial begin
      int sent;
      int batch;
      sb               = new();
      send_gaps        = 1'b0;
      recv_stalls      = 1'b0;
      req_if.valid     = 1'b0;
      req_if.data_byte = 8'h00;
      csr_psel         = 1'b0;
      csr_penable      = 1'b0;
      csr_pwrite       = 1'b0;
      csr_paddr        = '0;
      csr_pwdata       = '0;
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // reset settings: zero key and nonce, 20 rounds
      send_byte(8'h00);
      send_byte(8'hFF);
      send_byte(8'h55);
      send_byte(8'hAA);
      send_byte(8'h01);
      send_byte(8'h80);
      end_burst();
      wait_idle();

      // all-ones key and nonce, odd round count
      for (int k = 0; k < KEY_PAIRS; k++) csr_write(csr_reg_type'(k), '1);
      csr_write(REG_ROUNDS, 64'd31);
      csr_write(REG_NONCE, '1);
      send_byte(8'h00);
      send_byte(8'hFF);
      send_byte(8'h0F);
      send_byte(8'hF0);
      end_burst();
      wait_idle();

      // zero rounds: block is the doubled input
      csr_write(REG_ROUNDS, 64'd0);
      csr_write(REG_NONCE, 64'd0);
      send_byte(8'h00);
      send_byte(8'hFF);
      send_byte(8'h3C);
      end_burst();
      wait_idle();

      // one round also runs no double round
      csr_write(REG_ROUNDS, 64'd1);
      csr_write(REG_NONCE, 64'h0123_4567_89AB_CDEF);
      send_byte(8'hC3);
      send_byte(8'h7E);
      end_burst();
      wait_idle();

      // key and rounds changed mid-block keep the current block
      csr_write(REG_KEY0, 64'hDEAD_BEEF_0BAD_F00D);
      csr_write(REG_ROUNDS, 64'd20);
      send_byte(8'h96);
      send_byte(8'h69);
      end_burst();
      wait_idle();

      sent = 0;
      while (sent < RANDOM_BYTES) begin
         random_setup();
         send_gaps   = ($urandom_range(0, 3) != 0);
         recv_stalls = ($urandom_range(0, 3) != 0);
         batch = $urandom_range(1, 200);
         repeat (batch) send_byte(pick_byte());
         end_burst();
         sent += batch;
         wait_idle();
      end

      repeat (DRAIN_CYCLES) @(posedge clock);
      if (sb.failures == 0 && sb.pending() == 0) begin
         $display("** chacha_keystream_xor: PASSED **");
      end else begin
         $display("** chacha_keystream_xor: FAILED **");
      end
      $finish;
   end

endmodule
